// ===== rtl/core/caf_pkg.sv =====
// Shared types and constants for the complementary attitude filter.
// Holds the controller/datapath command and status structs and the arctangent table.
// No dependencies.
`timescale 1ns / 1ps

package caf_pkg;

  localparam int unsigned IN_W      = 16;
  localparam int unsigned ANG_W     = 19;
  localparam int unsigned VEC_W     = 27;
  localparam int unsigned Z_W       = 21;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned SQRT_ITER = 24;
  localparam int unsigned BLEND_LEN = 10;

  localparam logic signed [Z_W-1:0] PI_FX     = 21'sd205888;
  localparam logic signed [Z_W-1:0] TWO_PI_FX = 21'sd411775;
  localparam logic signed [55:0]    ANG_MAX   = 56'sd262143;
  localparam logic signed [55:0]    ANG_MIN   = -56'sd262144;
  localparam logic [15:0]           ALPHA_ONE = 16'd32768;

  localparam logic [7:0] CFG_BLEND_WEIGHT  = 8'd0;
  localparam logic [7:0] CFG_SAMPLE_PERIOD = 8'd1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_SQRT, ST_ROLL_LOAD, ST_ROLL, ST_BLEND, ST_OUTPUT
  } state_e;

  typedef enum logic [2:0] {
    MS_DT_RX, MS_DT_RY, MS_DT_RZ, MS_ALPHA_PROD,
    MS_ALPHA_PREV_P, MS_ALPHA_PREV_R, MS_BETA_ACC_P, MS_BETA_ACC_R
  } msel_e;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD_SH
  } acc_e;

  typedef struct packed {
    logic             capture;
    logic             prep;
    logic             sqrt_step;
    logic             cordic_step;
    logic             roll_load;
    logic [CNT_W-1:0] idx;
    msel_e            msel;
    acc_e             acc;
    logic             pitch_wr;
    logic             roll_wr;
    logic             yaw_wr;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  function automatic logic signed [Z_W-1:0] atan_lut(input logic [CNT_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:    v = 21'sd51472;
      5'd1:    v = 21'sd30385;
      5'd2:    v = 21'sd16055;
      5'd3:    v = 21'sd8150;
      5'd4:    v = 21'sd4091;
      5'd5:    v = 21'sd2047;
      5'd6:    v = 21'sd1024;
      5'd7:    v = 21'sd512;
      5'd8:    v = 21'sd256;
      5'd9:    v = 21'sd128;
      5'd10:   v = 21'sd64;
      5'd11:   v = 21'sd32;
      5'd12:   v = 21'sd16;
      5'd13:   v = 21'sd8;
      5'd14:   v = 21'sd4;
      5'd15:   v = 21'sd2;
      5'd16:   v = 21'sd1;
      default: v = 21'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/caf_ctrl.sv =====
// Sequencing state machine for the complementary attitude filter.
// Issues commands to caf_dp; depends on caf_pkg.
`timescale 1ns / 1ps

module caf_ctrl #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  caf_pkg::status_t status_i,
  output caf_pkg::cmd_t    cmd_o
);

  localparam logic [caf_pkg::CNT_W-1:0] CordicLast = caf_pkg::CNT_W'(CORDIC_STEPS - 1);
  localparam logic [caf_pkg::CNT_W-1:0] SqrtLast   = caf_pkg::CNT_W'(caf_pkg::SQRT_ITER - 1);
  localparam logic [caf_pkg::CNT_W-1:0] BlendLast  = caf_pkg::CNT_W'(caf_pkg::BLEND_LEN - 1);

  caf_pkg::state_e             state_q, state_d;
  logic [caf_pkg::CNT_W-1:0]   cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= caf_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.idx  = cnt_q;
    cmd_o.msel = caf_pkg::MS_DT_RX;
    cmd_o.acc  = caf_pkg::ACC_HOLD;
    unique case (state_q)
      caf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = caf_pkg::ST_PREP;
        end
      end
      caf_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        state_d    = caf_pkg::ST_SQRT;
      end
      caf_pkg::ST_SQRT: begin
        cmd_o.sqrt_step   = 1'b1;
        cmd_o.cordic_step = (cnt_q <= CordicLast);
        if (cnt_q == SqrtLast) begin
          state_d = caf_pkg::ST_ROLL_LOAD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      caf_pkg::ST_ROLL_LOAD: begin
        cmd_o.roll_load = 1'b1;
        cnt_d           = '0;
        state_d         = caf_pkg::ST_ROLL;
      end
      caf_pkg::ST_ROLL: begin
        cmd_o.cordic_step = 1'b1;
        if (cnt_q == CordicLast) begin
          cnt_d   = '0;
          state_d = caf_pkg::ST_BLEND;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      caf_pkg::ST_BLEND: begin
        case (cnt_q)
          5'd0: cmd_o.msel = caf_pkg::MS_DT_RX;
          5'd1: cmd_o.msel = caf_pkg::MS_ALPHA_PROD;
          5'd2: begin
            cmd_o.msel = caf_pkg::MS_ALPHA_PREV_P;
            cmd_o.acc  = caf_pkg::ACC_LOAD;
          end
          5'd3: begin
            cmd_o.msel = caf_pkg::MS_BETA_ACC_P;
            cmd_o.acc  = caf_pkg::ACC_ADD_SH;
          end
          5'd4: begin
            cmd_o.msel = caf_pkg::MS_DT_RY;
            cmd_o.acc  = caf_pkg::ACC_ADD_SH;
          end
          5'd5: begin
            cmd_o.msel     = caf_pkg::MS_ALPHA_PROD;
            cmd_o.pitch_wr = 1'b1;
          end
          5'd6: begin
            cmd_o.msel = caf_pkg::MS_ALPHA_PREV_R;
            cmd_o.acc  = caf_pkg::ACC_LOAD;
          end
          5'd7: begin
            cmd_o.msel = caf_pkg::MS_BETA_ACC_R;
            cmd_o.acc  = caf_pkg::ACC_ADD_SH;
          end
          5'd8: begin
            cmd_o.msel = caf_pkg::MS_DT_RZ;
            cmd_o.acc  = caf_pkg::ACC_ADD_SH;
          end
          default: begin
            cmd_o.roll_wr = 1'b1;
            cmd_o.yaw_wr  = 1'b1;
          end
        endcase
        if (cnt_q == BlendLast) begin
          state_d = caf_pkg::ST_OUTPUT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      caf_pkg::ST_OUTPUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = caf_pkg::ST_IDLE;
        end
      end
      default: state_d = caf_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/caf_dp.sv =====
// Datapath of the complementary attitude filter: square root, CORDIC, blend and output register.
// Driven by caf_ctrl commands; depends on caf_pkg.
`timescale 1ns / 1ps

module caf_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  caf_pkg::cmd_t       cmd_i,
  output caf_pkg::status_t    status_o,
  input  logic [95:0]         in_data_i,
  input  logic                cfg_valid_i,
  input  logic [7:0]          cfg_addr_i,
  input  logic [15:0]         cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [63:0]         out_data_o
);

  logic [15:0] blend_weight_q, sample_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_weight_q  <= 16'd32113;
      sample_period_q <= 16'd16777;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        caf_pkg::CFG_BLEND_WEIGHT:  blend_weight_q  <= cfg_data_i;
        caf_pkg::CFG_SAMPLE_PERIOD: sample_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [15:0] alpha, beta;
  assign alpha = (blend_weight_q > caf_pkg::ALPHA_ONE) ? caf_pkg::ALPHA_ONE : blend_weight_q;
  assign beta  = caf_pkg::ALPHA_ONE - alpha;

  logic signed [15:0] ax_q, ay_q, az_q, rx_q, ry_q, rz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ax_q <= in_data_i[15:0];
      ay_q <= in_data_i[31:16];
      az_q <= in_data_i[47:32];
      rx_q <= in_data_i[63:48];
      ry_q <= in_data_i[79:64];
      rz_q <= in_data_i[95:80];
    end
  end

  // Digit-by-digit square root, one result bit per cycle.
  logic [47:0] n_q;
  logic [25:0] rem_q;
  logic [23:0] root_q;
  logic [31:0] sq_sum;
  logic [27:0] rem_ext, trial;

  assign sq_sum  = 32'(32'(ay_q) * 32'(ay_q)) + 32'(32'(az_q) * 32'(az_q));
  assign rem_ext = {rem_q, n_q[47:46]};
  assign trial   = {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      n_q    <= {sq_sum, 16'h0000};
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      n_q <= {n_q[45:0], 2'b00};
      if (rem_ext >= trial) begin
        rem_q  <= 26'(rem_ext - trial);
        root_q <= {root_q[22:0], 1'b1};
      end else begin
        rem_q  <= rem_ext[25:0];
        root_q <= {root_q[22:0], 1'b0};
      end
    end
  end

  // Vectoring CORDIC shared by pitch and roll.
  logic signed [caf_pkg::VEC_W-1:0] cx_q, cy_q, ld_x, ld_y, dx, dy;
  logic signed [caf_pkg::Z_W-1:0]   cz_q, cordic_res, accp_q;
  logic                             czero_q;
  logic signed [caf_pkg::VEC_W-1:0] ax_s, ay_s, az_s;

  assign ax_s = caf_pkg::VEC_W'(ax_q) <<< 8;
  assign ay_s = caf_pkg::VEC_W'(ay_q) <<< 8;
  assign az_s = caf_pkg::VEC_W'(az_q) <<< 8;
  assign ld_y = cmd_i.roll_load ? -ax_s : ay_s;
  assign ld_x = cmd_i.roll_load ? $signed({3'b000, root_q}) : az_s;
  assign dx   = cy_q >>> cmd_i.idx;
  assign dy   = cx_q >>> cmd_i.idx;
  assign cordic_res = czero_q ? '0 : cz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.roll_load) begin
      accp_q <= cordic_res;
    end
    if (cmd_i.prep || cmd_i.roll_load) begin
      czero_q <= (ld_x == '0) && (ld_y == '0);
      if (ld_x < 0) begin
        cx_q <= -ld_x;
        cy_q <= -ld_y;
        cz_q <= (ld_y >= 0) ? caf_pkg::PI_FX : -caf_pkg::PI_FX;
      end else begin
        cx_q <= ld_x;
        cy_q <= ld_y;
        cz_q <= '0;
      end
    end else if (cmd_i.cordic_step) begin
      if (cy_q >= 0) begin
        cx_q <= cx_q + dx;
        cy_q <= cy_q - dy;
        cz_q <= cz_q + caf_pkg::atan_lut(cmd_i.idx);
      end else begin
        cx_q <= cx_q - dx;
        cy_q <= cy_q + dy;
        cz_q <= cz_q - caf_pkg::atan_lut(cmd_i.idx);
      end
    end
  end

  // Shared multiplier and accumulator for the blend.
  logic [16:0]        opa;
  logic signed [33:0] opb;
  logic signed [51:0] mul_p, prod_q;
  logic signed [55:0] sum_q, rnd;
  logic signed [caf_pkg::ANG_W-1:0] pitch_q, roll_q, sat_val;
  logic [caf_pkg::ANG_W-1:0]        yaw_q;
  logic signed [caf_pkg::Z_W-1:0]   yaw_inc, yaw_sum, yaw_wrap;

  always_comb begin
    opa = {1'b0, alpha};
    opb = $signed(prod_q[33:0]);
    case (cmd_i.msel)
      caf_pkg::MS_DT_RX: begin
        opa = {1'b0, sample_period_q};
        opb = 34'(rx_q);
      end
      caf_pkg::MS_DT_RY: begin
        opa = {1'b0, sample_period_q};
        opb = 34'(ry_q);
      end
      caf_pkg::MS_DT_RZ: begin
        opa = {1'b0, sample_period_q};
        opb = 34'(rz_q);
      end
      caf_pkg::MS_ALPHA_PREV_P: opb = 34'(pitch_q);
      caf_pkg::MS_ALPHA_PREV_R: opb = 34'(roll_q);
      caf_pkg::MS_BETA_ACC_P: begin
        opa = {1'b0, beta};
        opb = 34'(accp_q);
      end
      caf_pkg::MS_BETA_ACC_R: begin
        opa = {1'b0, beta};
        opb = 34'(cordic_res);
      end
      default: ;
    endcase
  end

  assign mul_p = $signed({1'b0, opa}) * opb;
  assign rnd   = (sum_q + (56'sd1 <<< 32)) >>> 33;
  assign sat_val = (rnd > caf_pkg::ANG_MAX) ? caf_pkg::ANG_W'(caf_pkg::ANG_MAX) :
                   (rnd < caf_pkg::ANG_MIN) ? caf_pkg::ANG_W'(caf_pkg::ANG_MIN) :
                   caf_pkg::ANG_W'(rnd);
  assign yaw_inc  = caf_pkg::Z_W'((prod_q + 52'sd131072) >>> 18);
  assign yaw_sum  = $signed({2'b00, yaw_q}) + yaw_inc;
  assign yaw_wrap = (yaw_sum >= caf_pkg::TWO_PI_FX) ? yaw_sum - caf_pkg::TWO_PI_FX :
                    (yaw_sum < 0) ? yaw_sum + caf_pkg::TWO_PI_FX : yaw_sum;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    case (cmd_i.acc)
      caf_pkg::ACC_LOAD:   sum_q <= 56'(prod_q);
      caf_pkg::ACC_ADD_SH: sum_q <= sum_q + (56'(prod_q) <<< 18);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q <= '0;
      roll_q  <= '0;
      yaw_q   <= '0;
    end else begin
      if (cmd_i.pitch_wr) pitch_q <= sat_val;
      if (cmd_i.roll_wr)  roll_q  <= sat_val;
      if (cmd_i.yaw_wr)   yaw_q   <= caf_pkg::ANG_W'(yaw_wrap);
    end
  end

  logic        out_valid_q;
  logic [56:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= {yaw_q, roll_q, pitch_q};
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = {7'b0, out_q};
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

// ===== rtl/core/complementary_attitude_filter_unit.sv =====
// Top level of the complementary attitude filter.
// Instantiates caf_ctrl and caf_dp; depends on caf_pkg.
`timescale 1ns / 1ps

// One IMU sample is taken on the slave stream, one set of fused angles leaves on the master
// stream. Configuration writes go through the cfg channel, which is always ready; index 0 is
// the blend weight and index 1 the sample period, other indexes are ignored. Write it only
// while the unit is idle.
// A sample passes from transfer to result through capture and preparation; the square root
// runs beside the pitch CORDIC, and the roll CORDIC and the shared blend multiplier follow in
// turn. One sample is in work at a time, so a new sample is taken after the result has been
// written to the output register.
// The output register holds its result while the receiver stalls; the next sample is still
// processed and waits only for that register to be free.
// Reset clears the angle estimates to zero, restores the register defaults and empties the
// output register.

module complementary_attitude_filter_unit #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z (16 bits each), lowest first.
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pitch_angle, roll_angle, yaw_angle (19 bits each), lowest first, then zero fill.
  output logic [63:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i
);

  caf_pkg::cmd_t    cmd;
  caf_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  caf_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  caf_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (s_axis_tdata),
    .cfg_valid_i(cfg_valid_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule
